// File: rtl/aging_priority_queue_defines.svh
// assertion macros used by the aging priority queue top level
`ifndef AGING_PRIORITY_QUEUE_DEFINES_SVH
`define AGING_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define APQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("aging priority queue check failed");

// next-cycle implication
`define APQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("aging priority queue check failed");

`endif

// File: rtl/apq_pkg.sv
// shared constants, codes and types of the aging priority queue
package apq_pkg;

    localparam int DEPTH      = 16;
    localparam int ID_BITS    = 16;
    localparam int PRIO_BITS  = 8;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    localparam logic OP_INSERT   = 1'b0;
    localparam logic OP_RETRIEVE = 1'b1;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_RETRIEVED = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_BADPRIO   = 3'd4;

    typedef struct packed {
        logic                 valid;
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic                 insert;
        logic                 retrieve;
        logic [ID_BITS-1:0]   new_id;
        logic [PRIO_BITS-1:0] new_prio;
    } cell_ctrl_t;

endpackage

// File: rtl/apq_cell.sv
// one queue cell: holds an entry, shifts back on insert, forward with aging on retrieve
module apq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  apq_pkg::cell_ctrl_t ctrl,
    input  apq_pkg::entry_t    prev_entry,
    input  logic               prev_keep,
    input  apq_pkg::entry_t    next_entry,
    output apq_pkg::entry_t    entry,
    output logic               keep
);
    import apq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    assign keep  = entry_reg.valid && (entry_reg.prio <= ctrl.new_prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.insert) begin
            if (!keep) begin
                if (prev_keep) begin
                    entry_next.valid = 1'b1;
                    entry_next.id    = ctrl.new_id;
                    entry_next.prio  = ctrl.new_prio;
                end else begin
                    entry_next = prev_entry;
                end
            end
        end else if (ctrl.retrieve) begin
            entry_next = next_entry;
            // aging, floor at 1
            if (next_entry.prio > PRIO_BITS'(1)) begin
                entry_next.prio = next_entry.prio - PRIO_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

// File: rtl/aging_priority_queue.sv
// top level of the aging priority queue: request decode, cell chain, result register
//
// channel  direction  handshake              payload
// s_       in         s_tvalid / s_tready    s_tuser operation, s_tdata id and priority
// m_       out        m_tvalid / m_tready    m_tdata served id, status, fill count
// cfg_     in         cfg_valid / cfg_ready  cfg_data priority ceiling
//
// one request per cycle while s_tready is high; every cell updates in the cycle a valid insert or retrieve is accepted
// the result is captured in the output register at the end of the cycle the request is accepted
// s_tready is low only while a result waits and m_tready is low
// synchronous active-low reset empties the queue and sets the priority ceiling to 255
`include "aging_priority_queue_defines.svh"

module aging_priority_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] entry_id, [23:16] entry_priority
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] served_id, [18:16] status, [23:19] fill_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import apq_pkg::*;

    logic                  accept;
    logic                  op;
    logic [ID_BITS-1:0]    in_id;
    logic [PRIO_BITS-1:0]  in_prio;
    logic                  bad_prio;
    logic                  is_full;
    logic                  is_empty;
    logic                  empty_retrieve;
    logic [2:0]            status;
    logic                  do_insert;
    logic                  do_retrieve;
    cell_ctrl_t            ctrl;

    logic [7:0]            prio_ceiling_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  out_valid_reg;
    logic [ID_BITS-1:0]    out_id_reg;
    logic [2:0]            out_status_reg;
    logic [COUNT_BITS-1:0] out_count_reg;

    entry_t                cell_q [DEPTH];
    logic                  cell_keep [DEPTH];
    logic [DEPTH-1:0]      valid_vec;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign op      = s_tuser[0];
    assign in_id   = s_tdata[ID_BITS-1:0];
    assign in_prio = s_tdata[ID_BITS +: PRIO_BITS];

    assign bad_prio = (in_prio == '0) || (in_prio > prio_ceiling_reg);
    assign is_full  = (count_reg == COUNT_BITS'(DEPTH));
    assign is_empty = (count_reg == '0);

    assign empty_retrieve = accept && (op == OP_RETRIEVE) && is_empty;

    always_comb begin
        if (op == OP_INSERT) begin
            status = bad_prio ? ST_BADPRIO : (is_full ? ST_FULL : ST_INSERTED);
        end else begin
            status = is_empty ? ST_EMPTY : ST_RETRIEVED;
        end
    end

    assign do_insert   = accept && (op == OP_INSERT) && (status == ST_INSERTED);
    assign do_retrieve = accept && (op == OP_RETRIEVE) && (status == ST_RETRIEVED);

    assign ctrl.insert   = do_insert;
    assign ctrl.retrieve = do_retrieve;
    assign ctrl.new_id   = in_id;
    assign ctrl.new_prio = in_prio;

    always_comb begin
        count_next = count_reg;
        if (do_insert) begin
            count_next = count_reg + COUNT_BITS'(1);
        end else if (do_retrieve) begin
            count_next = count_reg - COUNT_BITS'(1);
        end
    end

    localparam entry_t EMPTY_ENTRY = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   prev_k;

        if (i == 0) begin : g_first
            assign prev_e = EMPTY_ENTRY;
            assign prev_k = 1'b1;
        end else begin : g_mid
            assign prev_e = cell_q[i-1];
            assign prev_k = cell_keep[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_e = EMPTY_ENTRY;
        end else begin : g_inner
            assign next_e = cell_q[i+1];
        end

        apq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .prev_entry (prev_e),
            .prev_keep  (prev_k),
            .next_entry (next_e),
            .entry      (cell_q[i]),
            .keep       (cell_keep[i])
        );

        assign valid_vec[i] = cell_q[i].valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prio_ceiling_reg <= 8'd255;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                prio_ceiling_reg <= cfg_data;
            end
            count_reg <= count_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_id_reg     <= do_retrieve ? cell_q[0].id : '0;
            out_status_reg <= status;
            out_count_reg  <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_status_reg, out_id_reg};

    // occupied cells form an unbroken run from the front
    `APQ_ASSERT_NOW(a_valid_packed, aclk, aresetn, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0)
    // fill counter agrees with the occupied cells
    `APQ_ASSERT_NOW(a_count_match, aclk, aresetn, 1'b1, $countones(valid_vec) == 32'(count_reg))
    // a retrieve from an empty queue reports empty
    `APQ_ASSERT_NEXT(a_empty_reject, aclk, aresetn, empty_retrieve, out_status_reg == ST_EMPTY)
    // front entry never has a larger priority than the one behind it
    `APQ_ASSERT_NOW(a_front_sorted, aclk, aresetn, cell_q[1].valid, cell_q[0].prio <= cell_q[1].prio)

endmodule

// File: bench/tb_top.sv
// self-checking testbench for the aging priority queue: directed table, then random phases
`timescale 1ns / 1ps

module tb_top;
    import apq_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 160;

    typedef struct packed {
        logic [COUNT_BITS-1:0] fill;
        logic [2:0]            status;
        logic [ID_BITS-1:0]    served;
    } result_t;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] prio;
    } waiting_t;

    typedef struct {
        logic                 op;
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] prio;
        bit                   fixed;
        result_t              want;
    } step_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    bit                   calm = 1'b0;
    int                   mismatches = 0;
    int                   quiet_cycles = 0;
    logic [PRIO_BITS-1:0] prio_limit = 8'd255;
    waiting_t             shadow_entries[$];
    result_t              pending_results[$];

    int phase_limit [PHASES]      = '{255, 1, 0, 2, -1, 255, 16, -1};
    int phase_insert_pct [PHASES] = '{55, 60, 50, 65, 50, 55, 45, 60};

    step_t opening_steps [25] = '{
        '{OP_RETRIEVE, 16'h0000, 8'd0,   1'b1, '{5'd0,  ST_EMPTY,     16'h0000}},
        '{OP_INSERT,   16'hFFFF, 8'd0,   1'b1, '{5'd0,  ST_BADPRIO,   16'h0000}},
        '{OP_INSERT,   16'hFFFF, 8'd255, 1'b1, '{5'd1,  ST_INSERTED,  16'h0000}},
        '{OP_INSERT,   16'h0000, 8'd1,   1'b1, '{5'd2,  ST_INSERTED,  16'h0000}},
        '{OP_INSERT,   16'h1234, 8'd1,   1'b0, '0},
        '{OP_INSERT,   16'hA5A5, 8'd128, 1'b0, '0},
        '{OP_INSERT,   16'h5A5A, 8'd2,   1'b0, '0},
        '{OP_INSERT,   16'h0F0F, 8'd2,   1'b0, '0},
        '{OP_INSERT,   16'hF0F0, 8'd7,   1'b0, '0},
        '{OP_INSERT,   16'h8000, 8'd254, 1'b0, '0},
        '{OP_INSERT,   16'h0001, 8'd1,   1'b0, '0},
        '{OP_INSERT,   16'h7FFF, 8'd64,  1'b0, '0},
        '{OP_INSERT,   16'h00FF, 8'd3,   1'b0, '0},
        '{OP_INSERT,   16'hFF00, 8'd200, 1'b0, '0},
        '{OP_INSERT,   16'h3C3C, 8'd5,   1'b0, '0},
        '{OP_INSERT,   16'hC3C3, 8'd5,   1'b0, '0},
        '{OP_INSERT,   16'hAAAA, 8'd100, 1'b0, '0},
        '{OP_INSERT,   16'h5555, 8'd9,   1'b0, '0},
        '{OP_INSERT,   16'h4321, 8'd10,  1'b1, '{5'd16, ST_FULL,      16'h0000}},
        '{OP_INSERT,   16'h4321, 8'd0,   1'b1, '{5'd16, ST_BADPRIO,   16'h0000}},
        '{OP_RETRIEVE, 16'h0000, 8'd0,   1'b1, '{5'd15, ST_RETRIEVED, 16'h0000}},
        '{OP_RETRIEVE, 16'hFFFF, 8'd255, 1'b0, '0},
        '{OP_RETRIEVE, 16'h2468, 8'd17,  1'b0, '0},
        '{OP_RETRIEVE, 16'h1357, 8'd1,   1'b0, '0},
        '{OP_INSERT,   16'hBEEF, 8'd255, 1'b0, '0}
    };

    aging_priority_queue dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [15:0] entry_id, [23:16] entry_priority
        .s_tuser   (s_tuser),   // [0] operation
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [15:0] served_id, [18:16] status, [23:19] fill_count
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic apply_request(input logic op, input logic [ID_BITS-1:0] id,
                                 input logic [PRIO_BITS-1:0] prio, output result_t res);
        int slot;
        waiting_t front;
        res = '0;
        res.status = ST_INSERTED;
        if (op == OP_INSERT) begin
            if (prio == 0 || prio > prio_limit) begin
                res.status = ST_BADPRIO;
            end else if (shadow_entries.size() >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                slot = 0;
                while (slot < shadow_entries.size() && shadow_entries[slot].prio <= prio)
                    slot++;
                shadow_entries.insert(slot, '{id: id, prio: prio});
            end
        end else if (shadow_entries.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            front = shadow_entries.pop_front();
            res.status = ST_RETRIEVED;
            res.served = front.id;
            // aging of what is left, floor at 1
            foreach (shadow_entries[k])
                if (shadow_entries[k].prio > 1) shadow_entries[k].prio--;
        end
        res.fill = COUNT_BITS'(shadow_entries.size());
    endtask

    function automatic logic [PRIO_BITS-1:0] pick_priority();
        int r = $urandom_range(0, 99);
        int top;
        if (prio_limit == 0 || r < 8) return PRIO_BITS'($urandom_range(0, 255));
        if (r < 12) return '0;
        top = (prio_limit < 4 || r >= 40) ? int'(prio_limit) : 4;
        return PRIO_BITS'($urandom_range(1, top));
    endfunction

    task automatic put_request(input logic op, input logic [ID_BITS-1:0] id,
                               input logic [PRIO_BITS-1:0] prio,
                               input bit fixed, input result_t fixed_result);
        result_t outcome;
        while (!calm && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {prio, id};
        do @(posedge aclk); while (!s_tready);
        apply_request(op, id, prio, outcome);
        pending_results.push_back(fixed ? fixed_result : outcome);
    endtask

    task automatic write_limit(input logic [7:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        prio_limit = value;
    endtask

    initial begin : stimulus
        logic                 op;
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] prio;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (opening_steps[i])
            put_request(opening_steps[i].op, opening_steps[i].id, opening_steps[i].prio,
                        opening_steps[i].fixed, opening_steps[i].want);
        for (int ph = 0; ph < PHASES; ph++) begin
            write_limit(phase_limit[ph] < 0 ? 8'($urandom_range(3, 254)) : 8'(phase_limit[ph]));
            calm <= (ph == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op   = ($urandom_range(0, 99) < phase_insert_pct[ph]) ? OP_INSERT : OP_RETRIEVE;
                id   = ID_BITS'($urandom_range(0, 65535));
                prio = pick_priority();
                put_request(op, id, prio, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.served) begin
                    $display("%0t: served_id expected %h actual %h",
                             $time, want.served, m_tdata[15:0]);
                    mismatches++;
                end
                if (m_tdata[18:16] !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tdata[18:16]);
                    mismatches++;
                end
                if (m_tdata[23:19] !== want.fill) begin
                    $display("%0t: fill_count expected %0d actual %0d",
                             $time, want.fill, m_tdata[23:19]);
                    mismatches++;
                end
            end
        end
        m_tready <= calm || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/apq_pkg.sv
rtl/apq_cell.sv
rtl/aging_priority_queue.sv
bench/tb_top.sv
